// File: rtl/mavlink_v2_frame_checker_core_assert.svh
// Assertion macros for the frame checker core.
`ifndef MAVLINK_V2_FRAME_CHECKER_CORE_ASSERT_SVH
`define MAVLINK_V2_FRAME_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MVCHK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mvchk assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MVCHK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mvchk assertion failed");

`endif

// File: rtl/mvchk_pkg.sv
`timescale 1ns / 1ps

package mvchk_pkg;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CRC_LO  = 3'd3,
        PH_CRC_HI  = 3'd4,
        PH_SIGN    = 3'd5
    } phase_t;

    localparam logic [7:0]  MARKER_V2      = 8'hFD;
    localparam logic [7:0]  HEADER_LAST    = 8'd8;
    localparam logic [7:0]  SIGNATURE_LEN  = 8'd13;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic        KIND_PAYLOAD   = 1'b0;
    localparam logic        KIND_SUMMARY   = 1'b1;

    localparam logic [7:0] HDR_LEN  = 8'd0;
    localparam logic [7:0] HDR_INC  = 8'd1;
    localparam logic [7:0] HDR_SEQ  = 8'd3;
    localparam logic [7:0] HDR_SYS  = 8'd4;
    localparam logic [7:0] HDR_COMP = 8'd5;
    localparam logic [7:0] HDR_MSG0 = 8'd6;
    localparam logic [7:0] HDR_MSG1 = 8'd7;
    localparam logic [7:0] HDR_MSG2 = 8'd8;

    // CRC-16/MCRF4XX, one byte
    function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] crc);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'h0};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b0, t, 3'b0} ^ {12'h000, t[7:4]};
    endfunction

endpackage

// File: rtl/mavlink_v2_frame_checker_core.sv
`timescale 1ns / 1ps
// MAVLink v2 frame checker.
// Byte channel: byte_valid / byte_stall carry data_byte and extra_seed, one
// stream byte per item; extra_seed matters only with the first checksum byte.
// Result channel: result_valid / result_stall carry one item per payload byte
// (kind 0) and one summary per frame (kind 1) on the second checksum byte,
// with the header fields and crc_good.
// Path: a byte is accepted into the input register, then the CRC/parse stage
// writes the result register, which drives result_valid.
// Throughput: one byte per cycle while byte_stall is low; the CRC update is one byte per cycle.
// Bytes that cause no result (header, checksum low, signature, hunting)
// move on even while the result register is held.
// When result_stall holds a result and the next byte would make another one,
// byte_stall rises until the result is taken; nothing is dropped.
// Reset (rst_n low, asynchronous): hunting for the 0xFD marker, input and
// result registers empty.
module mavlink_v2_frame_checker_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  extra_seed,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [7:0]  sequence_number,
    output logic [7:0]  system_ident,
    output logic [7:0]  component_ident,
    output logic [23:0] message_ident,
    output logic [7:0]  payload_length,
    output logic        is_signed,
    output logic        crc_good
);
    import mvchk_pkg::*;

    logic        in_vld_reg, in_vld_next;
    logic [7:0]  in_byte_reg, in_extra_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  len_reg, len_next;
    logic        sgn_reg, sgn_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  rcrc_lo_reg, rcrc_lo_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  sys_reg, sys_next;
    logic [7:0]  comp_reg, comp_next;
    logic [23:0] msg_reg, msg_next;

    logic        res_vld_reg, res_vld_next;
    logic        kind_reg, good_reg;
    logic [7:0]  pbyte_reg;
    logic [7:0]  rseq_reg, rsys_reg, rcomp_reg, rlen_reg;
    logic [23:0] rmsg_reg;
    logic        rsgn_reg;

    logic        emits;
    logic        adv;
    logic        load_in;
    logic [7:0]  cnt_inc;
    logic        emit_kind;
    logic        emit_good;
    logic [7:0]  emit_byte;

    assign emits   = in_vld_reg && (phase_reg == PH_PAYLOAD || phase_reg == PH_CRC_HI);
    assign adv     = in_vld_reg && (!emits || !res_vld_reg || !result_stall);
    assign load_in = !in_vld_reg || adv;
    assign cnt_inc = cnt_reg + 8'd1;

    assign byte_stall  = in_vld_reg && !adv;
    assign in_vld_next = load_in ? byte_valid : in_vld_reg;

    // next phase and byte counter
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (adv)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (cnt_reg == HEADER_LAST)
                    begin
                        cnt_next   = 8'd0;
                        phase_next = (len_reg == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (cnt_inc >= len_reg)
                    begin
                        cnt_next   = 8'd0;
                        phase_next = PH_CRC_LO;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
                PH_CRC_LO:
                begin
                    phase_next = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    cnt_next   = 8'd0;
                    phase_next = sgn_reg ? PH_SIGN : PH_HUNT;
                end
                PH_SIGN:
                begin
                    if (cnt_inc >= SIGNATURE_LEN)
                    begin
                        cnt_next   = 8'd0;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
                default:
                begin
                    if (in_byte_reg == MARKER_V2)
                    begin
                        phase_next = PH_HEADER;
                        cnt_next   = 8'd0;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    // datapath: CRC, header capture, result
    always_comb
    begin
        crc_next     = crc_reg;
        len_next     = len_reg;
        sgn_next     = sgn_reg;
        rcrc_lo_next = rcrc_lo_reg;
        seq_next     = seq_reg;
        sys_next     = sys_reg;
        comp_next    = comp_reg;
        msg_next     = msg_reg;
        emit_kind    = KIND_PAYLOAD;
        emit_good    = 1'b0;
        emit_byte    = 8'd0;
        if (adv)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    crc_next = crc_step(in_byte_reg, crc_reg);
                    case (cnt_reg)
                        HDR_LEN:  len_next  = in_byte_reg;
                        HDR_INC:  sgn_next  = in_byte_reg[0];
                        HDR_SEQ:  seq_next  = in_byte_reg;
                        HDR_SYS:  sys_next  = in_byte_reg;
                        HDR_COMP: comp_next = in_byte_reg;
                        HDR_MSG0: msg_next  = {16'h0000, in_byte_reg};
                        HDR_MSG1: msg_next[15:8]  = in_byte_reg;
                        HDR_MSG2: msg_next[23:16] = in_byte_reg;
                        default:  ;
                    endcase
                end
                PH_PAYLOAD:
                begin
                    crc_next  = crc_step(in_byte_reg, crc_reg);
                    emit_byte = in_byte_reg;
                end
                PH_CRC_LO:
                begin
                    rcrc_lo_next = in_byte_reg;
                    crc_next     = crc_step(in_extra_reg, crc_reg);
                end
                PH_CRC_HI:
                begin
                    emit_kind = KIND_SUMMARY;
                    emit_good = (crc_reg == {in_byte_reg, rcrc_lo_reg});
                end
                PH_SIGN:  ;
                default:
                begin
                    if (in_byte_reg == MARKER_V2)
                    begin
                        crc_next     = CRC_INIT;
                        len_next     = 8'd0;
                        sgn_next     = 1'b0;
                        seq_next     = 8'd0;
                        sys_next     = 8'd0;
                        comp_next    = 8'd0;
                        msg_next     = 24'd0;
                        rcrc_lo_next = 8'd0;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res_vld_next = res_vld_reg && result_stall;
        if (adv && emits)
        begin
            res_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
            phase_reg   <= PH_HUNT;
            cnt_reg     <= 8'd0;
            len_reg     <= 8'd0;
            sgn_reg     <= 1'b0;
            crc_reg     <= CRC_INIT;
            rcrc_lo_reg <= 8'd0;
            seq_reg     <= 8'd0;
            sys_reg     <= 8'd0;
            comp_reg    <= 8'd0;
            msg_reg     <= 24'd0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_vld_reg <= res_vld_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            len_reg     <= len_next;
            sgn_reg     <= sgn_next;
            crc_reg     <= crc_next;
            rcrc_lo_reg <= rcrc_lo_next;
            seq_reg     <= seq_next;
            sys_reg     <= sys_next;
            comp_reg    <= comp_next;
            msg_reg     <= msg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_byte_reg  <= data_byte;
            in_extra_reg <= extra_seed;
        end
        if (adv && emits)
        begin
            kind_reg  <= emit_kind;
            good_reg  <= emit_good;
            pbyte_reg <= emit_byte;
            rseq_reg  <= seq_reg;
            rsys_reg  <= sys_reg;
            rcomp_reg <= comp_reg;
            rmsg_reg  <= msg_reg;
            rlen_reg  <= len_reg;
            rsgn_reg  <= sgn_reg;
        end
    end

    assign result_valid    = res_vld_reg;
    assign kind            = kind_reg;
    assign payload_byte    = pbyte_reg;
    assign sequence_number = rseq_reg;
    assign system_ident    = rsys_reg;
    assign component_ident = rcomp_reg;
    assign message_ident   = rmsg_reg;
    assign payload_length  = rlen_reg;
    assign is_signed       = rsgn_reg;
    assign crc_good        = good_reg;

`include "mavlink_v2_frame_checker_core_assert.svh"

    `MVCHK_ASSERT_NOW(a_stall_needs_item, byte_stall, in_vld_reg && emits && res_vld_reg)
    `MVCHK_ASSERT_NOW(a_hdr_count, phase_reg == PH_HEADER, cnt_reg <= HEADER_LAST)
    `MVCHK_ASSERT_NOW(a_sign_count, phase_reg == PH_SIGN, cnt_reg < SIGNATURE_LEN)
    `MVCHK_ASSERT_NOW(a_payload_no_good, res_vld_reg && kind_reg == KIND_PAYLOAD, !good_reg)
    `MVCHK_ASSERT_NEXT(a_summary_out, adv && phase_reg == PH_CRC_HI, res_vld_reg && kind_reg == KIND_SUMMARY)

endmodule
